@@ src/assert_macros.svh @@
// Assertion macros shared by the pool allocator modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define OPA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition never holds at a clock edge outside reset.
`define OPA_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ src/opa_pkg.sv @@
// Shared types and constants for the object pool allocator.
// Used by opa_front, opa_queue, opa_back and object_pool_allocator.
package opa_pkg;

	localparam int HANDLE_W = 12;
	localparam int COUNT_W = 13;
	localparam int CFG_DATA_W = COUNT_W;
	localparam int POOL_DEPTH_DEF = 4096;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(4096);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_RECYCLE = 2'd1,
		CMD_ROLLBACK = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FRESH = 2'd0,
		ST_RECYCLED = 2'd1,
		ST_OOM = 2'd2,
		ST_DONE = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_RECYCLE_ENABLE = 1'b0,
		CFG_CAPACITY = 1'b1
	} cfg_idx_t;

	// One classified request on its way from the front end to the back end.
	typedef struct packed {
		logic [1:0] command;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0] count;
		logic [HANDLE_W-1:0] idx;
	} opa_item_t;

	// Queue fill status seen by the front end.
	typedef struct packed {
		logic full;
		logic empty;
	} opa_qstat_t;

endpackage

@@ src/opa_front.sv @@
// Front end: takes requests, computes the link memory index of the handle.
// Depends on opa_pkg; feeds opa_queue.
module opa_front import opa_pkg::*; #(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] command,
	input  logic [HANDLE_W-1:0] handle_in,
	input  logic [COUNT_W-1:0] rollback_count,
	input  opa_qstat_t q_stat,
	output logic push,
	output opa_item_t push_item
);

	// Handles never exceed the handle space, so larger pools act as that size.
	localparam int HANDLE_SPAN = 1 << HANDLE_W;
	localparam int MOD_DEP = (POOL_DEPTH > HANDLE_SPAN) ? HANDLE_SPAN : POOL_DEPTH;
	localparam int SHIFT = HANDLE_W + $clog2(MOD_DEP);
	localparam int RECIP = ((1 << SHIFT) + MOD_DEP - 1) / MOD_DEP;
	localparam int RECIP_W = HANDLE_W + 2;
	localparam int PROD_W = HANDLE_W + RECIP_W;
	localparam int DEP_W = HANDLE_W + 1;
	localparam int QD_W = HANDLE_W + DEP_W;

	logic valid_s1;
	logic [1:0] cmd_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [COUNT_W-1:0] count_s1;
	logic [PROD_W-1:0] prod_s1;
	logic accept;
	logic [PROD_W-1:0] quot_wide;
	logic [HANDLE_W-1:0] quot;
	logic [QD_W-1:0] quot_dep;

	// The stage holds while the queue is full.
	assign busy = valid_s1 & q_stat.full;
	assign accept = start & ~busy;
	assign push = valid_s1 & ~q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | busy;
		end
	end

	// Capture the request and the reciprocal product of the handle.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			handle_s1 <= handle_in;
			count_s1 <= rollback_count;
			prod_s1 <= PROD_W'(handle_in) * PROD_W'(RECIP_W'(RECIP));
		end
	end

	// Quotient from the product, then remainder by one constant multiply.
	assign quot_wide = prod_s1 >> SHIFT;
	assign quot = quot_wide[HANDLE_W-1:0];
	assign quot_dep = QD_W'(quot) * QD_W'(DEP_W'(MOD_DEP));

	always_comb begin
		push_item.command = cmd_s1;
		push_item.handle = handle_s1;
		push_item.count = count_s1;
		push_item.idx = handle_s1 - quot_dep[HANDLE_W-1:0];
	end

endmodule

@@ src/opa_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on opa_pkg and assert_macros.svh.
module opa_queue import opa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  opa_item_t push_item,
	input  logic pop,
	output opa_item_t pop_item,
	output opa_qstat_t q_stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	opa_item_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign q_stat.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push = push & ~q_stat.full;
	assign do_pop = pop & ~q_stat.empty;
	assign pop_item = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`include "assert_macros.svh"

	`OPA_ASSERT_NEVER(a_push_when_full, push && q_stat.full, "queue written while full")
	`OPA_ASSERT_NEVER(a_count_range, count_q > CNT_W'(QUEUE_DEPTH), "queue count overrun")
	`OPA_ASSERT(a_pop_drains, do_pop && !do_push && count_q == CNT_W'(1) |=> q_stat.empty,
		"queue not empty after last entry left")

endmodule

@@ src/opa_back.sv @@
// Back end: bump counter, recycle list head and the next-link memory.
// Depends on opa_pkg and assert_macros.svh; drains opa_queue.
module opa_back import opa_pkg::*; #(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic recycle_enable,
	input  logic [COUNT_W-1:0] capacity,
	input  opa_qstat_t q_stat,
	input  opa_item_t pop_item,
	output logic pop,
	output logic done,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [1:0] status
);

	localparam int HANDLE_SPAN = 1 << HANDLE_W;
	localparam int MOD_DEP = (POOL_DEPTH > HANDLE_SPAN) ? HANDLE_SPAN : POOL_DEPTH;
	localparam int IDX_W = $clog2(MOD_DEP);
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;
	localparam int POOL_CAP = (POOL_DEPTH > COUNT_MAX) ? COUNT_MAX : POOL_DEPTH;

	typedef enum logic {
		B_IDLE,
		B_POP
	} bstate_t;

	// One link entry: end-of-list mark, next handle and its memory index.
	typedef struct packed {
		logic last;
		logic [HANDLE_W-1:0] next;
		logic [IDX_W-1:0] nidx;
	} link_t;

	bstate_t state_q;
	logic [COUNT_W-1:0] bump_q;
	logic [HANDLE_W-1:0] head_q;
	logic [IDX_W-1:0] head_idx_q;
	logic free_empty_q;
	link_t link_mem [MOD_DEP];
	link_t link_rd_q;
	logic [COUNT_W-1:0] eff_cap;
	logic do_push;
	logic do_read;

	assign pop = (state_q == B_IDLE) & ~q_stat.empty;
	assign eff_cap = (capacity > COUNT_W'(POOL_CAP)) ? COUNT_W'(POOL_CAP) : capacity;
	assign do_push = pop & (pop_item.command == CMD_RECYCLE) & recycle_enable;
	assign do_read = pop & (pop_item.command == CMD_ALLOC) & ~free_empty_q;

	// Next-link memory: push writes, allocate from the list reads the head.
	always_ff @(posedge clk) begin
		if (do_push) begin
			link_mem[pop_item.idx[IDX_W-1:0]] <= '{last: free_empty_q, next: head_q,
				nidx: head_idx_q};
		end
		if (do_read) begin
			link_rd_q <= link_mem[head_idx_q];
		end
	end

	// Command execution and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			bump_q <= '0;
			head_q <= '0;
			head_idx_q <= '0;
			free_empty_q <= 1'b1;
			done <= 1'b0;
			handle_out <= '0;
			status <= ST_DONE;
		end else begin
			done <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						handle_out <= '0;
						status <= ST_DONE;
						done <= 1'b1;
						case (pop_item.command)
							CMD_ALLOC: begin
								if (!free_empty_q) begin
									// Result waits for the link read.
									done <= 1'b0;
									state_q <= B_POP;
								end else if (bump_q < eff_cap) begin
									handle_out <= bump_q[HANDLE_W-1:0];
									status <= ST_FRESH;
									bump_q <= bump_q + COUNT_W'(1);
								end else begin
									status <= ST_OOM;
								end
							end
							CMD_RECYCLE: begin
								if (recycle_enable) begin
									head_q <= pop_item.handle;
									head_idx_q <= pop_item.idx[IDX_W-1:0];
									free_empty_q <= 1'b0;
								end
							end
							CMD_ROLLBACK: begin
								bump_q <= (pop_item.count >= bump_q) ? '0 :
									bump_q - pop_item.count;
							end
							default: begin
							end
						endcase
					end
				end
				B_POP: begin
					done <= 1'b1;
					handle_out <= head_q;
					status <= ST_RECYCLED;
					free_empty_q <= link_rd_q.last;
					head_q <= link_rd_q.last ? '0 : link_rd_q.next;
					head_idx_q <= link_rd_q.nidx;
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

`include "assert_macros.svh"

	`OPA_ASSERT(a_pop_needs_list, state_q == B_POP |-> !free_empty_q,
		"list pop started on an empty list")
	`OPA_ASSERT(a_pop_result, state_q == B_POP |=> done && status == ST_RECYCLED,
		"list pop gave no recycled result")
	`OPA_ASSERT(a_push_fills_list, do_push |=> !free_empty_q && state_q == B_IDLE,
		"recycle did not leave the list non-empty")

endmodule

@@ src/object_pool_allocator.sv @@
// Pool allocator: a request passes the front stage register, the two-entry queue and the
// result register, where result strobe done marks it; an allocate served from the recycle list also passes B_POP.
// Throughput is one request per cycle, except a list pop, which holds the back
// end in B_POP for the registered next-link memory read; busy rises when the
// two-entry queue and the front stage are full. The receiver cannot stall results.
// Reset clears the counters, the list head and the registers; not the link memory.
module object_pool_allocator import opa_pkg::*; #(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] command,
	input  logic [HANDLE_W-1:0] handle_in,
	input  logic [COUNT_W-1:0] rollback_count,
	output logic done,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [1:0] status,
	input  logic cfg_write,
	input  logic [0:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic recycle_enable_q;
	logic [COUNT_W-1:0] capacity_q;
	logic push;
	logic pop;
	opa_item_t push_item;
	opa_item_t pop_item;
	opa_qstat_t q_stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recycle_enable_q <= 1'b1;
			capacity_q <= CAP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RECYCLE_ENABLE: recycle_enable_q <= cfg_data[0];
				CFG_CAPACITY: capacity_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	opa_front #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.handle_in(handle_in),
		.rollback_count(rollback_count),
		.q_stat(q_stat),
		.push(push),
		.push_item(push_item)
	);

	opa_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.pop_item(pop_item),
		.q_stat(q_stat)
	);

	opa_back #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.recycle_enable(recycle_enable_q),
		.capacity(capacity_q),
		.q_stat(q_stat),
		.pop_item(pop_item),
		.pop(pop),
		.done(done),
		.handle_out(handle_out),
		.status(status)
	);

endmodule

@@ tb/sv/pool_check_pkg.sv @@
// Prediction and checking for the object pool allocator testbench.
// Holds a scoreboard class that tracks the allocator state; depends on opa_pkg.
package pool_check_pkg;
	import opa_pkg::*;

	// One expected reply of the allocator.
	typedef struct {
		bit [HANDLE_W-1:0] handle;
		status_t status;
	} reply_t;

	class pool_scoreboard;
		// Register copies.
		bit recycle_on;
		bit [COUNT_W-1:0] cap_limit;

		// Allocator state: bump counter, recycle list head and its link memory.
		bit [COUNT_W-1:0] bump;
		bit [HANDLE_W-1:0] head;
		bit list_empty;
		bit [HANDLE_W-1:0] link_mem [POOL_DEPTH_DEF];
		bit link_tail [POOL_DEPTH_DEF];

		reply_t replies[$];
		int unsigned failures;

		function new();
			recycle_on = 1'b1;
			cap_limit = CAP_RESET;
			bump = '0;
			head = '0;
			list_empty = 1'b1;
			failures = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] data);
			if (idx == CFG_RECYCLE_ENABLE) begin
				recycle_on = data[0];
			end else begin
				cap_limit = data[COUNT_W-1:0];
			end
		endfunction

		// Works out the reply to an accepted request and updates the state.
		function reply_t note_request(bit [1:0] cmd, bit [HANDLE_W-1:0] hin,
				bit [COUNT_W-1:0] cnt);
			reply_t r;
			int unsigned usable;
			int unsigned slot;
			r.handle = '0;
			r.status = ST_DONE;
			usable = (cap_limit > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : cap_limit;
			case (cmd)
				CMD_ALLOC: begin
					if (!list_empty) begin
						// Pop the most recently recycled handle.
						slot = head % POOL_DEPTH_DEF;
						r.handle = head;
						r.status = ST_RECYCLED;
						list_empty = link_tail[slot];
						head = list_empty ? '0 : link_mem[slot];
					end else if (bump < usable) begin
						r.handle = bump[HANDLE_W-1:0];
						r.status = ST_FRESH;
						bump = bump + 1'b1;
					end else begin
						r.status = ST_OOM;
					end
				end
				CMD_RECYCLE: begin
					// Push onto the list; ignored while recycling is disabled.
					if (recycle_on) begin
						slot = hin % POOL_DEPTH_DEF;
						link_mem[slot] = head;
						link_tail[slot] = list_empty;
						head = hin;
						list_empty = 1'b0;
					end
				end
				CMD_ROLLBACK: begin
					// Lower the bump counter, saturating at zero.
					bump = (cnt >= bump) ? '0 : bump - cnt;
				end
				default: begin
				end
			endcase
			replies.push_back(r);
			return r;
		endfunction

		// Compares one reply of the block with the oldest expectation.
		function void check_result(logic [HANDLE_W-1:0] hout, logic [1:0] st);
			reply_t r;
			if (replies.size() == 0) begin
				$error("unexpected result: handle_out %0d status %0d", hout, st);
				failures++;
				return;
			end
			r = replies.pop_front();
			if (hout !== r.handle) begin
				$error("handle_out: expected %0d, actual %0d", r.handle, hout);
				failures++;
			end
			if (st !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, st);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return replies.size();
		endfunction
	endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top level of the object pool allocator testbench: clock, reset, stimulus.
// Depends on opa_pkg, pool_check_pkg and the object_pool_allocator RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import opa_pkg::*;
	import pool_check_pkg::*;

	// Command code the block treats as no operation.
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 138;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] command = CMD_ALLOC;
	logic [HANDLE_W-1:0] handle_in = '0;
	logic [COUNT_W-1:0] rollback_count = '0;
	logic done;
	logic [HANDLE_W-1:0] handle_out;
	logic [1:0] status;
	logic cfg_write = 1'b0;
	logic [0:0] cfg_index = CFG_RECYCLE_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned cycle_count = 0;
	pool_scoreboard tracker = new();
	bit [HANDLE_W-1:0] live_handles[$];

	object_pool_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.handle_in(handle_in),
		.rollback_count(rollback_count),
		.done(done),
		.handle_out(handle_out),
		.status(status),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("object_pool_allocator: mismatch");
			$finish;
		end
	end

	// Every strobed result is taken at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			tracker.check_result(handle_out, status);
		end
	end

	// Presents one request and holds it until the block accepts it.
	task automatic issue(input logic [1:0] cmd, input logic [HANDLE_W-1:0] hin,
			input logic [COUNT_W-1:0] cnt);
		reply_t r;
		start <= 1'b1;
		command <= cmd;
		handle_in <= hin;
		rollback_count <= cnt;
		do @(posedge clk); while (busy);
		r = tracker.note_request(cmd, hin, cnt);
		if (cmd == CMD_ALLOC && r.status != ST_OOM) begin
			live_handles.push_back(r.handle);
		end
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits until every expected result has come and the block has gone quiet.
	task automatic settle();
		start <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input bit enable, input logic [COUNT_W-1:0] cap);
		cfg_write <= 1'b1;
		cfg_index <= CFG_RECYCLE_ENABLE;
		cfg_data <= CFG_DATA_W'(enable);
		@(posedge clk);
		cfg_index <= CFG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.write_reg(CFG_RECYCLE_ENABLE, CFG_DATA_W'(enable));
		tracker.write_reg(CFG_CAPACITY, cap);
	endtask

	// One random request: mostly allocations and recycles of live handles.
	task automatic random_request();
		logic [1:0] cmd;
		logic [HANDLE_W-1:0] hin;
		logic [COUNT_W-1:0] cnt;
		int unsigned pick;
		int unsigned pos;
		hin = HANDLE_W'($urandom_range(0, 4095));
		cnt = COUNT_W'($urandom_range(0, 8191));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			cmd = CMD_ALLOC;
		end else if (pick < 75) begin
			cmd = CMD_RECYCLE;
			if (live_handles.size() != 0 && $urandom_range(0, 99) < 70) begin
				pos = $urandom_range(0, live_handles.size() - 1);
				hin = live_handles[pos];
				live_handles.delete(pos);
			end
		end else if (pick < 92) begin
			cmd = CMD_ROLLBACK;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				cnt = COUNT_W'($urandom_range(0, 3));
			end else if (pick < 85) begin
				cnt = COUNT_W'($urandom_range(0, 31));
			end else if (pick >= 95) begin
				cnt = (pick[0]) ? COUNT_W'(8191) : COUNT_W'(4096);
			end
		end else begin
			cmd = CMD_NOP;
		end
		issue(cmd, hin, cnt);
	endtask

	initial begin
		bit phase_enable [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		int phase_cap [PHASES] = '{3, 4096, 16, 1, 0, 8191, 64, 4096};
		int unsigned idle_pct;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bump allocation up to a small capacity, out of memory,
		// list pushes and pops in last-in-first-out order, rollback extremes.
		write_regs(1'b1, COUNT_W'(2));
		issue(CMD_ALLOC, 12'hFFF, 13'h1FFF);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_ALLOC, 12'h5A5, 13'h0A5A);
		issue(CMD_RECYCLE, 12'h000, 13'h0000);
		issue(CMD_RECYCLE, 12'hFFF, 13'h1FFF);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_ROLLBACK, 12'h000, 13'h0000);
		issue(CMD_ROLLBACK, 12'hFFF, 13'h0001);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_ROLLBACK, 12'h000, 13'h1FFF);
		issue(CMD_NOP, 12'hFFF, 13'h1FFF);
		issue(CMD_RECYCLE, 12'hAAA, 13'h1555);
		issue(CMD_RECYCLE, 12'h555, 13'h0AAA);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		settle();

		// Capacity zero with recycling disabled: nothing can be handed out.
		write_regs(1'b0, COUNT_W'(0));
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_RECYCLE, 12'h123, 13'h0000);
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		settle();

		// Capacity above the pool size acts as the pool size.
		write_regs(1'b1, COUNT_W'(8191));
		issue(CMD_ALLOC, 12'h000, 13'h0000);
		issue(CMD_ROLLBACK, 12'h000, 13'h1000);
		settle();

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			write_regs(phase_enable[p], COUNT_W'(phase_cap[p]));
			idle_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 2) * 25;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				random_request();
				if ($urandom_range(1, 100) <= idle_pct) begin
					pause($urandom_range(1, 9));
				end
			end
			settle();
		end

		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("object_pool_allocator: match");
		end else begin
			$display("object_pool_allocator: mismatch");
		end
		$finish;
	end

endmodule
